// ===== src/s20_pkg.sv =====
// Shared types, constants and round function of the Salsa20 stream cipher.
// Depends on nothing; every other file of the block imports it.
package s20_pkg;

    typedef logic [15:0][31:0] t_state;
    typedef logic [3:0][63:0]  t_key;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_item;

    // Request from the byte sequencer to the round unit.
    typedef struct packed {
        logic        start;
        logic [63:0] counter;
    } t_gen_req;

    // Status from the round unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_gen_sts;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // Word indexes (a, b, c, d) of the four quarter rounds.
    localparam logic [3:0] COL_IDX [4][4] = '{
        '{4'd0,  4'd4,  4'd8,  4'd12},
        '{4'd5,  4'd9,  4'd13, 4'd1},
        '{4'd10, 4'd14, 4'd2,  4'd6},
        '{4'd15, 4'd3,  4'd7,  4'd11}
    };
    localparam logic [3:0] ROW_IDX [4][4] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3},
        '{4'd5,  4'd6,  4'd7,  4'd4},
        '{4'd10, 4'd11, 4'd8,  4'd9},
        '{4'd15, 4'd12, 4'd13, 4'd14}
    };

    function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One column round (row = 0) or one row round (row = 1).
    function automatic t_state s20_round(t_state x, logic row);
        t_state      y;
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        y = x;
        for (int q = 0; q < 4; q++) begin
            ia = row ? ROW_IDX[q][0] : COL_IDX[q][0];
            ib = row ? ROW_IDX[q][1] : COL_IDX[q][1];
            ic = row ? ROW_IDX[q][2] : COL_IDX[q][2];
            id = row ? ROW_IDX[q][3] : COL_IDX[q][3];
            a  = x[ia];
            b  = x[ib];
            c  = x[ic];
            d  = x[id];
            b  = b ^ rotl32(a + d, 7);
            c  = c ^ rotl32(b + a, 9);
            d  = d ^ rotl32(c + b, 13);
            a  = a ^ rotl32(d + c, 18);
            y[ia] = a;
            y[ib] = b;
            y[ic] = c;
            y[id] = d;
        end
        return y;
    endfunction

endpackage

// ===== src/salsa20_stream_cipher.sv =====
// Top level of the Salsa20 stream cipher: configuration registers, queue, round unit.
// Depends on s20_pkg, s20_fifo, s20_core and s20_back.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata = data_in, tlast = last_in_message
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata = data_out, tlast = last_out
//   cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data (64 bits)
//
// Throughput: one byte per cycle while a keystream block is current, bytes wait in the
// queue and the output register is not held. Each new 64-byte block (first byte of a
// message, and every 64th byte) holds the bytes while the sequencer starts the round
// unit, the unit runs ROUNDS rounds at one per cycle and the feed-forward add, and the
// sequencer takes the done flag.
// Reset: synchronous, active low; clears position, counter, keystream valid and the
// key/nonce registers. No clearing pass. Stalls: a QUEUE_DEPTH-word input queue and
// the output register let either side stall on its own.
module salsa20_stream_cipher
    import s20_pkg::*;
#(
    parameter int ROUNDS      = 20,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Stream slave: one message byte per word
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  logic        s_axis_tlast,   // last_in_message
    // Stream master: one result byte per word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_out
    output logic        m_axis_tlast,   // last_out
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [2:0] {
        CFG_KEY0  = 3'd0,
        CFG_KEY1  = 3'd1,
        CFG_KEY2  = 3'd2,
        CFG_KEY3  = 3'd3,
        CFG_NONCE = 3'd4
    } t_cfg_idx;

    t_key        r_key;
    logic [63:0] r_nonce;
    logic        fifo_full;
    logic        q_valid;
    t_item       q_item;
    t_item       in_item;
    logic        q_pop;
    t_gen_req    gen_req;
    t_gen_sts    gen_sts;
    logic [3:0]  word_sel;
    logic [31:0] ks_word;

    // Writes always land; an index past the list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_nonce <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY0:  r_key[0] <= i_cfg_data;
                CFG_KEY1:  r_key[1] <= i_cfg_data;
                CFG_KEY2:  r_key[2] <= i_cfg_data;
                CFG_KEY3:  r_key[3] <= i_cfg_data;
                CFG_NONCE: r_nonce  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: accept bytes into the queue whenever there is room.
    assign in_item.data  = s_axis_tdata;
    assign in_item.last  = s_axis_tlast;
    assign s_axis_tready = !fifo_full;

    s20_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_axis_tvalid),
        .i_push_item (in_item),
        .o_full      (fifo_full),
        .o_pop_valid (q_valid),
        .o_pop_item  (q_item),
        .i_pop       (q_pop)
    );

    // Back: generate keystream blocks on demand and XOR queued bytes.
    s20_core #(
        .ROUNDS (ROUNDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (r_key),
        .i_nonce    (r_nonce),
        .i_req      (gen_req),
        .o_sts      (gen_sts),
        .i_word_sel (word_sel),
        .o_word     (ks_word)
    );

    s20_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_req        (gen_req),
        .i_sts        (gen_sts),
        .o_word_sel   (word_sel),
        .i_ks_word    (ks_word),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

// ===== src/s20_fifo.sv =====
// Short input queue between the stream slave port and the byte sequencer.
// Depends on s20_pkg for the queued word type.
module s20_fifo
    import s20_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_item  = r_mem[r_rd];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

// ===== src/s20_core.sv =====
// Salsa20 round unit: one column or row round per cycle, then the feed-forward add.
// Depends on s20_pkg for the state type and the round function.
module s20_core
    import s20_pkg::*;
#(
    parameter int ROUNDS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_key        i_key,
    input  logic [63:0] i_nonce,
    input  t_gen_req    i_req,
    output t_gen_sts    o_sts,
    input  logic [3:0]  i_word_sel,
    output logic [31:0] o_word
);

    localparam int RW = $clog2(ROUNDS + 1);

    t_state        r_x;
    t_state        r_init;
    logic [RW-1:0] r_rnd;
    logic          r_busy;
    logic          r_done;
    t_state        init_state;
    t_state        sum_state;

    always_comb begin
        init_state     = '0;
        init_state[0]  = SIGMA0;
        init_state[5]  = SIGMA1;
        init_state[10] = SIGMA2;
        init_state[15] = SIGMA3;
        init_state[1]  = i_key[0][31:0];
        init_state[2]  = i_key[0][63:32];
        init_state[3]  = i_key[1][31:0];
        init_state[4]  = i_key[1][63:32];
        init_state[11] = i_key[2][31:0];
        init_state[12] = i_key[2][63:32];
        init_state[13] = i_key[3][31:0];
        init_state[14] = i_key[3][63:32];
        init_state[6]  = i_nonce[63:32];
        init_state[7]  = i_nonce[31:0];
        init_state[8]  = i_req.counter[31:0];
        init_state[9]  = i_req.counter[63:32];
    end

    always_comb begin
        for (int w = 0; w < 16; w++) begin
            sum_state[w] = r_x[w] + r_init[w];
        end
    end

    // Control: busy from start until the feed-forward add, done for one cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_rnd == RW'(ROUNDS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_rnd <= r_rnd + 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end
        end
    end

    // State words carry no reset; the keystream is read only after a finished run.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_rnd == RW'(ROUNDS)) begin
                r_x <= sum_state;
            end else begin
                r_x <= s20_round(r_x, r_rnd[0]);
            end
        end else if (i_req.start) begin
            r_x    <= init_state;
            r_init <= init_state;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_word     = r_x[i_word_sel];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("round unit done without a preceding run");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rnd <= RW'(ROUNDS))
        else $error("round counter past its limit");

endmodule

// ===== src/s20_back.sv =====
// Byte sequencer: requests keystream blocks, XORs queued bytes, holds the output word.
// Depends on s20_pkg for the queued word type and the round unit interface.
module s20_back
    import s20_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output t_gen_req    o_req,
    input  t_gen_sts    i_sts,
    output logic [3:0]  o_word_sel,
    input  logic [31:0] i_ks_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data,
    output logic        o_last
);

    typedef enum logic {
        S_RUN,
        S_GEN
    } t_state_e;

    t_state_e    r_state;
    t_state_e    n_state;
    logic [5:0]  r_pos;
    logic [5:0]  n_pos;
    logic [63:0] r_counter;
    logic [63:0] n_counter;
    logic        r_ks_valid;
    logic        n_ks_valid;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_out_data;
    logic [7:0]  n_out_data;
    logic        r_out_last;
    logic        n_out_last;
    logic        slot_free;
    logic [7:0]  ks_byte;

    assign slot_free  = !r_out_valid || i_ready;
    assign o_word_sel = r_pos[5:2];
    assign ks_byte    = i_ks_word[{r_pos[1:0], 3'b000} +: 8];

    assign o_pop         = (r_state == S_RUN) && i_item_valid && r_ks_valid && slot_free;
    assign o_req.start   = (r_state == S_RUN) && i_item_valid && !r_ks_valid;
    assign o_req.counter = r_counter;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_counter   = r_counter;
        n_ks_valid  = r_ks_valid;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_RUN: begin
                if (o_req.start) begin
                    n_state = S_GEN;
                end else if (o_pop) begin
                    n_out_valid = 1'b1;
                    n_out_data  = i_item.data ^ ks_byte;
                    n_out_last  = i_item.last;
                    // Drop the block at the message end or when its last byte is used.
                    if (i_item.last) begin
                        n_pos      = '0;
                        n_counter  = '0;
                        n_ks_valid = 1'b0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                        if (r_pos == 6'd63) begin
                            n_counter  = r_counter + 1'b1;
                            n_ks_valid = 1'b0;
                        end
                    end
                end
            end
            S_GEN: begin
                if (i_sts.done) begin
                    n_ks_valid = 1'b1;
                    n_state    = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_pos       <= '0;
            r_counter   <= '0;
            r_ks_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_counter   <= n_counter;
            r_ks_valid  <= n_ks_valid;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    a_no_pop_while_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN) |-> !o_pop && !i_sts.done || !o_pop)
        else $error("byte taken while a block is being generated");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_pos == 6'd0) && (r_counter == 64'd0) && !r_ks_valid)
        else $error("message end did not clear position and counter");

    a_fresh_block_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.last && (r_pos == 6'd63)) |=> !r_ks_valid && (r_pos == 6'd0))
        else $error("block wrap did not force a new block");

    a_start_only_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |-> !i_sts.busy)
        else $error("round unit started while busy");

endmodule

// ===== bench/salsa20_stream_cipher_tb.sv =====
// Self-checking regression bench for salsa20_stream_cipher: directed table, then random messages.
// Depends on s20_pkg (item type, sigma constants) and on the salsa20_stream_cipher RTL.
module salsa20_stream_cipher_tb;
    import s20_pkg::*;

    localparam int ROUNDS        = 20;
    localparam int RANDOM_BYTES  = 1100;
    localparam int CYCLE_LIMIT   = 400000;
    // Idle pause before a register write, and the tail wait at the end of the run.
    localparam int SETTLE_CYCLES = ROUNDS + 8;
    localparam int LONG_HOLD     = 300;

    typedef enum logic [2:0] {
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_NONCE, REG_SPARE5, REG_SPARE6, REG_SPARE7
    } cfg_reg_e;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

    // One directed row: a message byte (value[7:0]) or a register write.
    typedef struct packed {
        row_kind_e   kind;
        cfg_reg_e    idx;
        logic        last;
        logic [63:0] value;
        logic        last_exp;
    } stim_row_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [2:0]  i_cfg_index   = 3'd0;
    logic [63:0] i_cfg_data    = 64'd0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        o_cfg_ready;

    // Predicted cipher state: registers, current keystream block, position, counter.
    logic [7:0][31:0] key_w   = '0;
    logic [63:0]      nonce_r = '0;
    t_state           ks_block;
    logic [5:0]       ks_pos   = '0;
    logic [63:0]      blk_ctr  = '0;
    logic             ks_ready = 1'b0;

    t_item       expected_bytes[$];
    t_item       want;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned hold_left  = 0;
    bit          long_hold_req = 1'b0;
    bit          steady = 1'b0;   // when set, no input gaps and no new random receiver stalls

    // Directed table. The output last flag is typed in; the byte comes from the predictor.
    stim_row_t dir_rows [0:28] = '{
        // reset key and nonce: all zero
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'h00, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'hff, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b1, 64'h80, 1'b1},   // short final block
        '{ROW_BYTE, REG_KEY0,   1'b1, 64'h01, 1'b1},   // one-byte message, counter back at 0
        // all-ones key and nonce
        '{ROW_CFG,  REG_KEY0,   1'b0, 64'hffff_ffff_ffff_ffff, 1'b0},
        '{ROW_CFG,  REG_KEY1,   1'b0, 64'hffff_ffff_ffff_ffff, 1'b0},
        '{ROW_CFG,  REG_KEY2,   1'b0, 64'hffff_ffff_ffff_ffff, 1'b0},
        '{ROW_CFG,  REG_KEY3,   1'b0, 64'hffff_ffff_ffff_ffff, 1'b0},
        '{ROW_CFG,  REG_NONCE,  1'b0, 64'hffff_ffff_ffff_ffff, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'h55, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'haa, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'h7f, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b1, 64'hfe, 1'b1},
        // unknown indexes: writes must be dropped
        '{ROW_CFG,  REG_SPARE5, 1'b0, 64'h0123_4567_89ab_cdef, 1'b0},
        '{ROW_CFG,  REG_SPARE6, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b0},
        '{ROW_CFG,  REG_SPARE7, 1'b0, 64'h5555_5555_aaaa_aaaa, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'h00, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'hff, 1'b0},
        // write mid-block: the current block stays in use
        '{ROW_CFG,  REG_KEY0,   1'b0, 64'h0000_0000_ffff_ffff, 1'b0},
        '{ROW_CFG,  REG_NONCE,  1'b0, 64'hffff_ffff_0000_0000, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'h0f, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b1, 64'hf0, 1'b1},
        // checkerboard in the first two key words, zero and end bits after; single-bit nonce
        '{ROW_CFG,  REG_KEY0,   1'b0, 64'h5555_5555_5555_5555, 1'b0},
        '{ROW_CFG,  REG_KEY1,   1'b0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0},
        '{ROW_CFG,  REG_KEY2,   1'b0, 64'h0000_0000_0000_0000, 1'b0},
        '{ROW_CFG,  REG_KEY3,   1'b0, 64'h8000_0000_0000_0001, 1'b0},
        '{ROW_CFG,  REG_NONCE,  1'b0, 64'h0000_0001_0000_0000, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b0, 64'h3c, 1'b0},
        '{ROW_BYTE, REG_KEY0,   1'b1, 64'hc3, 1'b1}
    };

    salsa20_stream_cipher #(.ROUNDS(ROUNDS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] rot_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_state quarter_mix(t_state s, int a, int b, int c, int d);
        s[b] = s[b] ^ rot_left(s[a] + s[d], 7);
        s[c] = s[c] ^ rot_left(s[b] + s[a], 9);
        s[d] = s[d] ^ rot_left(s[c] + s[b], 13);
        s[a] = s[a] ^ rot_left(s[d] + s[c], 18);
        return s;
    endfunction

    // Build the input state from key, nonce and counter, mix it, add the input back.
    function automatic t_state salsa_block(logic [63:0] ctr);
        t_state init;
        t_state x;
        init[0]  = SIGMA0;
        init[5]  = SIGMA1;
        init[10] = SIGMA2;
        init[15] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init[1 + i]  = key_w[i];
            init[11 + i] = key_w[4 + i];
        end
        init[6] = nonce_r[63:32];
        init[7] = nonce_r[31:0];
        init[8] = ctr[31:0];
        init[9] = ctr[63:32];
        x = init;
        for (int r = 0; r < ROUNDS; r++) begin
            if (r % 2 == 0) begin
                x = quarter_mix(x, 0, 4, 8, 12);
                x = quarter_mix(x, 5, 9, 13, 1);
                x = quarter_mix(x, 10, 14, 2, 6);
                x = quarter_mix(x, 15, 3, 7, 11);
            end else begin
                x = quarter_mix(x, 0, 1, 2, 3);
                x = quarter_mix(x, 5, 6, 7, 4);
                x = quarter_mix(x, 10, 11, 8, 9);
                x = quarter_mix(x, 15, 12, 13, 14);
            end
        end
        for (int i = 0; i < 16; i++) begin
            x[i] = x[i] + init[i];
        end
        return x;
    endfunction

    // XOR one byte with the next keystream byte and advance position and counter.
    function automatic logic [7:0] cipher_byte(logic [7:0] d, logic l);
        logic [31:0] w;
        logic [7:0]  res;
        if (ks_pos == 6'd0 || !ks_ready) begin
            ks_block = salsa_block(blk_ctr);
            ks_ready = 1'b1;
        end
        w   = ks_block[ks_pos[5:2]];
        res = d ^ w[{ks_pos[1:0], 3'b000} +: 8];
        if (l) begin
            ks_pos  = 6'd0;
            blk_ctr = 64'd0;
        end else begin
            ks_pos = ks_pos + 6'd1;
            if (ks_pos == 6'd0) begin
                blk_ctr = blk_ctr + 64'd1;
            end
        end
        return res;
    endfunction

    // Mostly back-to-back words, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'haaaa_aaaa_5555_5555;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one byte, hold it until taken, then log its expected result.
    task automatic send_byte(input logic [7:0] d, input logic l, input logic last_exp);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_bytes.push_back('{last: last_exp, data: cipher_byte(d, l)});
        bytes_sent++;
    endtask

    // Stop offering, wait for every result, then let the round unit settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; valid stays high so writes may follow back to back.
    task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] v);
        int unsigned k;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        k = idx;
        if (k < 4) begin
            key_w[2 * k]     = v[31:0];
            key_w[2 * k + 1] = v[63:32];
        end else if (idx == REG_NONCE) begin
            nonce_r = v;
        end
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver pacing: random stalls, quiet stretches, and the long hold-off on request.
    always @(posedge i_clk) begin : rx_pacing
        int unsigned r;
        r = $urandom_range(0, 99);
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end else if (hold_left == 0 && !steady) begin
            if (r >= 97) begin
                hold_left = $urandom_range(15, 60);
            end else if (r >= 75) begin
                hold_left = $urandom_range(1, 3);
            end
        end
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: result word with nothing expected: data %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t: data_out expected %h actual %h",
                             $time, want.data, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last_out expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_cnt, expected_bytes.size());
            $display("salsa20_stream_cipher regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t   row;
        bit          prev_cfg;
        int unsigned target;
        int unsigned msg_cnt;
        int unsigned len;
        int unsigned split;
        int unsigned r;
        prev_cfg = 1'b0;
        msg_cnt  = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; drain before a group of writes, release after it.
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.kind == ROW_CFG) begin
                if (!prev_cfg) begin
                    drain();
                end
                cfg_write(row.idx, row.value);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) begin
                    cfg_release();
                end
                send_byte(row.value[7:0], row.last, row.last_exp);
                prev_cfg = 1'b0;
            end
        end

        // Random messages: mostly short, some crossing one or more block ends.
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            msg_cnt++;
            if (msg_cnt % 8 == 0) begin
                drain();
                repeat ($urandom_range(1, 5)) begin
                    cfg_write(cfg_reg_e'($urandom_range(0, 7)), pick_word());
                end
                cfg_release();
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = $urandom_range(1, 12);
            end else if (r < 85) begin
                len = $urandom_range(13, 63);
            end else if (r < 97) begin
                len = $urandom_range(64, 140);
            end else begin
                len = $urandom_range(190, 260);
            end
            steady = ($urandom_range(0, 5) == 0);
            // Hold the receiver off while a long message keeps coming: fill the queue.
            if (msg_cnt == 12) begin
                len           = 150;
                steady        = 1'b1;
                long_hold_req = 1'b1;
            end
            // Now and then retune the key or nonce in the middle of a message.
            split = (len > 4 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
            for (int i = 0; i < len; i++) begin
                if (split != 0 && i == split) begin
                    drain();
                    cfg_write(cfg_reg_e'($urandom_range(0, 4)), pick_word());
                    cfg_release();
                end
                send_byte(8'($urandom_range(0, 255)), i == len - 1, i == len - 1);
            end
        end
        steady = 1'b0;

        // Wait out every result, then a tail for stray words.
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("salsa20_stream_cipher regression: pass");
        end else begin
            $display("salsa20_stream_cipher regression: fail");
        end
        $finish;
    end

endmodule

// ===== salsa20_stream_cipher.f =====
src/s20_pkg.sv
src/s20_fifo.sv
src/s20_core.sv
src/s20_back.sv
src/salsa20_stream_cipher.sv
bench/salsa20_stream_cipher_tb.sv
